[sv/cmd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the chorus modulated delay block.
// No dependencies; every other file imports this package.
package cmd_pkg;

   typedef logic signed [15:0] sample_type;
   typedef logic [15:0]        level_type;
   typedef logic [1:0]         csr_index_type;
   typedef logic [31:0]        csr_data_type;

   // Register indexes on the configuration channel
   localparam csr_index_type CSR_DELAY_LENGTH = 2'd0;
   localparam csr_index_type CSR_PHASE_STEP   = 2'd1;
   localparam csr_index_type CSR_WET_LEVEL    = 2'd2;

   // Register reset values
   localparam logic [11:0] DELAY_LENGTH_RESET = 12'd1024;
   localparam logic [31:0] PHASE_STEP_RESET   = 32'd89478;
   localparam level_type   WET_LEVEL_RESET    = 16'd16384;

   // Q1.15 unity, used for wet clamp and the LFO midpoint
   localparam level_type   WET_FULL = 16'd32768;
   localparam logic [16:0] LFO_MID  = 17'd32768;

   // Shared multiplier geometry
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef logic signed [MUL_A_W-1:0] mul_a_type;
   typedef logic signed [MUL_B_W-1:0] mul_b_type;
   typedef logic signed [MUL_P_W-1:0] mul_p_type;

endpackage

[sv/cmd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample request, sample response, register write.
// Depends on cmd_pkg for payload types.
interface cmd_req_if;
   import cmd_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface cmd_rsp_if;
   import cmd_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface cmd_csr_if;
   import cmd_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

[sv/cmd_mul.sv]
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on cmd_pkg for operand and product types.
module cmd_mul (
   input  logic               clock,
   input  cmd_pkg::mul_a_type op_a,
   input  cmd_pkg::mul_b_type op_b,
   output cmd_pkg::mul_p_type prod
);
   import cmd_pkg::*;

   mul_p_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

[sv/cmd_sine_rom.sv]
`timescale 1ns / 1ps
// Quarter-wave sine table, built at elaboration from a Q30 odd polynomial.
// Registered read; depends on cmd_pkg for the entry type.
module cmd_sine_rom #(
   parameter int SINE_ENTRIES = 1024
) (
   input  logic                              clock,
   input  logic [$clog2(SINE_ENTRIES+1)-1:0] addr,
   output cmd_pkg::level_type                rd_data
);
   import cmd_pkg::*;

   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned COEF1   = 64'd1686629713;
   localparam longint unsigned COEF3   = 64'd693598668;
   localparam longint unsigned COEF5   = 64'd85569306;
   localparam longint unsigned COEF7   = 64'd5026995;
   localparam longint unsigned COEF9   = 64'd172272;
   localparam longint unsigned Q_CAP   = 64'd32768;

   level_type rom_tbl [SINE_ENTRIES+1];
   level_type rd_data_ff;

   for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_entry
      localparam longint unsigned T  = (64'(k) * Q30_ONE) / SINE_ENTRIES;
      localparam longint unsigned U  = (T * T) >> 30;
      localparam longint unsigned A7 = COEF7 - ((U * COEF9) >> 30);
      localparam longint unsigned A5 = COEF5 - ((U * A7) >> 30);
      localparam longint unsigned A3 = COEF3 - ((U * A5) >> 30);
      localparam longint unsigned A1 = COEF1 - ((U * A3) >> 30);
      localparam longint unsigned R  = (T * A1) >> 30;
      localparam longint unsigned RR = (R + 64'd16384) >> 15;
      localparam longint unsigned QV = (RR > Q_CAP) ? Q_CAP : RR;
      assign rom_tbl[k] = 16'(QV);
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom_tbl[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/chorus_modulated_delay_top.sv]
`timescale 1ns / 1ps
// Chorus effect: sine-LFO modulated fractional delay line, one Q1.15 sample per beat.
// Depends on cmd_pkg, the channel interfaces, cmd_mul and cmd_sine_rom.

// Each accepted sample beat is taken in the idle state, then passes through
// nine sequencer steps, ST_POS to ST_OUT, that share a single registered
// multiplier four times (LFO table position, delay = lfo * length, linear
// interpolation between two taps, wet gain) around a registered sine ROM read
// and a two-port read of the delay store. req ready drops for those steps and
// comes back once the result has been loaded into the output register; a
// result waiting on rsp does not block the next beat, but the final step holds
// until the previous result has been taken. After reset the block sweeps the
// delay store to zero, one entry a cycle, over all MAX_DELAY entries before it
// takes its first sample; register writes are taken at any time and csr ready is
// always high. Registers: 0 delay_length (1..MAX_DELAY, 0 acts as 1, larger
// values clamp), 1 phase_step (LFO increment per sample, wraps mod 2^32),
// 2 wet_level (Q1.15, clamped to 1.0). Output is x + wet * d, saturated.
module chorus_modulated_delay_top #(
   parameter int MAX_DELAY    = 2048,
   parameter int SINE_ENTRIES = 1024
) (
   input logic        clock,
   input logic        reset,
   cmd_csr_if.sink    csr_bus,
   cmd_req_if.sink    req_bus,
   cmd_rsp_if.source  rsp_bus
);
   import cmd_pkg::*;

   localparam int ADDR_W = $clog2(MAX_DELAY);
   localparam int LEN_W  = $clog2(MAX_DELAY + 1);
   localparam int ROM_AW = $clog2(SINE_ENTRIES + 1);
   localparam int K_W    = $clog2(SINE_ENTRIES);
   localparam int POS_W  = K_W + 2;
   localparam int FOUR_S = 4 * SINE_ENTRIES;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POS,
      ST_ROM,
      ST_LFO,
      ST_ADDR,
      ST_READ,
      ST_INTERP,
      ST_DSUM,
      ST_WET,
      ST_OUT
   } state_type;

   // Control state
   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sample_type        rsp_sample_ff, rsp_sample_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [31:0]       phase_ff, phase_in;
   logic [11:0]       dlen_ff, dlen_in;
   logic [31:0]       step_ff, step_in;
   level_type         wet_ff, wet_in;

   // Per-item working registers
   sample_type        x_ff;
   logic [LEN_W-1:0]  len_ff;
   level_type         wetc_ff;
   logic [1:0]        quad_ff;
   logic [15:0]       f_ff;
   logic [ADDR_W-1:0] i1_ff;
   sample_type        d_ff;
   sample_type        rd1_ff, rd2_ff;

   // Delay store
   sample_type        store_mem [MAX_DELAY];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   sample_type        mem_wdata;
   logic              mem_re;

   // Shared multiplier and sine ROM
   mul_a_type         mul_a;
   mul_b_type         mul_b;
   mul_p_type         prod;
   logic [ROM_AW-1:0] rom_addr;
   level_type         rom_data;

   // Combinational datapath
   logic              req_fire, rsp_fire, csr_fire;
   logic [LEN_W-1:0]  len_eff;
   level_type         wet_clamp;
   logic [POS_W-1:0]  pos;
   logic [1:0]        quad;
   logic [POS_W-1:0]  k_full;
   logic [K_W-1:0]    k;
   logic [16:0]       lfo;
   logic [LEN_W-1:0]  tap_n;
   logic [LEN_W:0]    tap_sum;
   logic [LEN_W:0]    tap_wrap;
   logic [ADDR_W-1:0] i1_calc;
   logic [ADDR_W-1:0] i2;
   logic signed [16:0] diff;
   logic signed [35:0] interp_sum;
   logic signed [33:0] wet_sum;
   logic signed [16:0] w_val;
   logic signed [17:0] y_val;
   sample_type        y_sat;
   logic              wp_last;

   cmd_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   cmd_sine_rom #(
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .rd_data (rom_data)
   );

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign csr_fire = csr_bus.valid && csr_bus.ready;

   assign csr_bus.ready     = 1'b1;
   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_sample_ff;

   // Effective length: zero acts as one, clamp at the store depth
   always_comb begin
      priority if (dlen_ff == 12'd0) begin
         len_eff = LEN_W'(1);
      end else if (32'(dlen_ff) > 32'(MAX_DELAY)) begin
         len_eff = LEN_W'(MAX_DELAY);
      end else begin
         len_eff = LEN_W'(dlen_ff);
      end
   end

   assign wet_clamp = (wet_ff > WET_FULL) ? WET_FULL : wet_ff;

   // Table position from phase * 4S; split into quadrant and offset by compare
   assign pos = prod[32 +: POS_W];

   always_comb begin
      priority if (32'(pos) >= 32'(3 * SINE_ENTRIES)) begin
         quad   = 2'd3;
         k_full = pos - POS_W'(3 * SINE_ENTRIES);
      end else if (32'(pos) >= 32'(2 * SINE_ENTRIES)) begin
         quad   = 2'd2;
         k_full = pos - POS_W'(2 * SINE_ENTRIES);
      end else if (32'(pos) >= 32'(SINE_ENTRIES)) begin
         quad   = 2'd1;
         k_full = pos - POS_W'(SINE_ENTRIES);
      end else begin
         quad   = 2'd0;
         k_full = pos;
      end
   end

   assign k        = k_full[K_W-1:0];
   assign rom_addr = quad[0] ? (ROM_AW'(SINE_ENTRIES) - ROM_AW'(k)) : ROM_AW'(k);

   // LFO in Q1.16: midpoint plus or minus the table value
   assign lfo = quad_ff[1] ? (LFO_MID - {1'b0, rom_data}) : (LFO_MID + {1'b0, rom_data});

   // Read taps: i1 = (wp + L - n) mod L with n <= L, so one wrap at most
   assign tap_n    = prod[16 +: LEN_W];
   assign tap_sum  = (LEN_W+1)'(wp_ff) + (LEN_W+1)'(len_ff) - (LEN_W+1)'(tap_n);
   assign tap_wrap = (tap_sum >= (LEN_W+1)'(len_ff)) ? (tap_sum - (LEN_W+1)'(len_ff))
                                                     : tap_sum;
   assign i1_calc  = tap_wrap[ADDR_W-1:0];
   assign i2       = (i1_ff == '0) ? ADDR_W'(len_ff - 1'b1) : (i1_ff - 1'b1);

   // Interpolation: b1*(1-f) + b2*f == b1*65536 + (b2-b1)*f
   assign diff       = 17'(rd2_ff) - 17'(rd1_ff);
   assign interp_sum = (36'(rd1_ff) <<< 16) + $signed(prod[35:0]) + 36'sd32768;

   // Wet gain with round half up, then saturate the dry plus wet sum
   assign wet_sum = $signed(prod[33:0]) + 34'sd16384;
   assign w_val   = wet_sum[31:15];
   assign y_val   = 18'(x_ff) + 18'(w_val);

   always_comb begin
      priority if (y_val > 18'sd32767) begin
         y_sat = 16'sh7fff;
      end else if (y_val < -18'sd32768) begin
         y_sat = 16'sh8000;
      end else begin
         y_sat = y_val[15:0];
      end
   end

   assign wp_last = (32'(wp_ff) + 32'd1 == 32'(len_ff));

   // Multiplier operand select: one use per multiplier step, zero elsewhere
   always_comb begin
      unique case (state_ff)
         ST_POS: begin
            mul_a = $signed({1'b0, phase_ff});
            mul_b = MUL_B_W'(FOUR_S);
         end
         ST_LFO: begin
            mul_a = $signed(MUL_A_W'(lfo));
            mul_b = $signed(MUL_B_W'(len_ff));
         end
         ST_INTERP: begin
            mul_a = MUL_A_W'(diff);
            mul_b = $signed({2'b00, f_ff});
         end
         ST_WET, ST_OUT: begin
            mul_a = MUL_A_W'(d_ff);
            mul_b = $signed({2'b00, wetc_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer next state and control register updates
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      clr_in        = clr_ff;
      wp_in         = wp_ff;
      phase_in      = phase_ff;
      dlen_in       = dlen_ff;
      step_in       = step_ff;
      wet_in        = wet_ff;
      mem_we        = 1'b0;
      mem_waddr     = wp_ff;
      mem_wdata     = x_ff;
      mem_re        = 1'b0;

      // Drop the result once taken; a new load below wins
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_fire) begin
         unique case (csr_bus.index)
            CSR_DELAY_LENGTH: dlen_in = csr_bus.wdata[11:0];
            CSR_PHASE_STEP:   step_in = csr_bus.wdata;
            CSR_WET_LEVEL:    wet_in  = csr_bus.wdata[15:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the store to zero before taking samples
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MAX_DELAY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               // Restart the pointer if the length was lowered below it
               if (32'(wp_ff) >= 32'(len_eff)) begin
                  wp_in = '0;
               end
               state_in = ST_POS;
            end
         end
         ST_POS:    state_in = ST_ROM;
         ST_ROM:    state_in = ST_LFO;
         ST_LFO:    state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_READ;
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            // Taps are already read, so the full-delay slot sees the old sample
            mem_we   = 1'b1;
            state_in = ST_DSUM;
         end
         ST_DSUM:   state_in = ST_WET;
         ST_WET:    state_in = ST_OUT;
         ST_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = y_sat;
               wp_in         = wp_last ? '0 : (wp_ff + 1'b1);
               phase_in      = phase_ff + step_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         wp_ff        <= '0;
         phase_ff     <= '0;
         dlen_ff      <= DELAY_LENGTH_RESET;
         step_ff      <= PHASE_STEP_RESET;
         wet_ff       <= WET_LEVEL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         phase_ff     <= phase_in;
         dlen_ff      <= dlen_in;
         step_ff      <= step_in;
         wet_ff       <= wet_in;
      end
   end

   // Per-item payload registers, loaded at the step that produces them
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff    <= req_bus.sample_in;
         len_ff  <= len_eff;
         wetc_ff <= wet_clamp;
      end
      if (state_ff == ST_ROM) begin
         quad_ff <= quad;
      end
      if (state_ff == ST_ADDR) begin
         i1_ff <= i1_calc;
         f_ff  <= prod[15:0];
      end
      if (state_ff == ST_DSUM) begin
         d_ff <= interp_sum[31:16];
      end
   end

   // Delay store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd1_ff <= store_mem[i1_ff];
         rd2_ff <= store_mem[i2];
      end
   end

endmodule

[sv/cmd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for chorus_modulated_delay_top, attached by bind.
// Depends on cmd_pkg for the sample type.
module cmd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input cmd_pkg::sample_type rsp_sample_out
);
   import cmd_pkg::*;

   // Hold a stalled result beat steady
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("result beat changed while stalled");

   // Clearing pass follows reset: no sample taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("sample ready during store clearing pass");

   // One sample at a time: busy right after an accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting a sample");

   // A new result only comes out of a busy sequencer
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without work in progress");

endmodule

bind chorus_modulated_delay_top cmd_checker u_cmd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_sample_out (rsp_bus.sample_out)
);

[sim/chorus_modulated_delay_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for chorus_modulated_delay_top: sends sample and register beats,
// predicts every output sample in step with the block and compares them in order.
// Depends on cmd_pkg, the channel interfaces in cmd_if.sv and the RTL top level.
module chorus_modulated_delay_top_tb;
   import cmd_pkg::*;

   localparam int MAX_DELAY    = 2048;
   localparam int SINE_ENTRIES = 1024;
   // Slowest legal run: clearing sweep plus ~1100 beats through the sequencer, stretched by
   // 71% idling on either side and the long output hold-off; take it many times over.
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;

   // Index with no register behind it; writes to it must change nothing
   localparam csr_index_type CSR_SPARE = 2'd3;

   // Q30 Taylor coefficients of sin(pi/2 * t)
   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned SIN_C1  = 64'd1686629713;
   localparam longint unsigned SIN_C3  = 64'd693598668;
   localparam longint unsigned SIN_C5  = 64'd85569306;
   localparam longint unsigned SIN_C7  = 64'd5026995;
   localparam longint unsigned SIN_C9  = 64'd172272;

   logic clock;
   logic reset;

   cmd_csr_if csr_bus ();
   cmd_req_if req_bus ();
   cmd_rsp_if rsp_bus ();

   chorus_modulated_delay_top #(
      .MAX_DELAY    (MAX_DELAY),
      .SINE_ENTRIES (SINE_ENTRIES)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow of the block: quarter-wave sine, delay taps, write head, LFO accumulator
   int          quarter_wave [0:SINE_ENTRIES];
   sample_type  tap_line [MAX_DELAY];
   int unsigned head_index;
   logic [31:0] lfo_acc;
   logic [11:0] cfg_length;
   logic [31:0] cfg_step;
   level_type   cfg_wet;

   sample_type  expected_samples [$];

   int req_idle_pct;
   int rsp_idle_pct;
   int rsp_hold_cycles;
   int mismatch_count;
   int samples_sent;
   int results_checked;
   int csr_writes;
   int settings_used;
   int cycle_count;

   // Work out the next output sample and advance the shadow state by one beat
   function automatic sample_type mix_chorus_sample(input sample_type x);
      int unsigned     len, wet, dq, frac, whole, i1, i2, k;
      longint unsigned pos;
      int              sine, lfo;
      longint          acc, dly, wet_term, y;
      len = (cfg_length == 0) ? 1 : 32'(cfg_length);
      if (len > MAX_DELAY) len = MAX_DELAY;
      wet = (cfg_wet > WET_FULL) ? 32'(WET_FULL) : 32'(cfg_wet);
      // A shortened line restarts the head before it is used
      if (head_index >= len) head_index = 0;

      pos = ({32'd0, lfo_acc} * 64'(4 * SINE_ENTRIES)) >> 32;
      k   = 32'(pos % SINE_ENTRIES);
      case ((pos / SINE_ENTRIES) % 4)
         0:       sine = quarter_wave[k];
         1:       sine = quarter_wave[SINE_ENTRIES - k];
         2:       sine = -quarter_wave[k];
         default: sine = -quarter_wave[SINE_ENTRIES - k];
      endcase
      lfo = 32768 + sine;

      dq    = lfo * len;
      whole = dq >> 16;
      frac  = dq & 32'hFFFF;
      i1    = (head_index + len - whole) % len;
      i2    = (i1 + len - 1) % len;

      acc      = longint'(tap_line[i1]) * longint'(65536 - frac)
               + longint'(tap_line[i2]) * longint'(frac);
      dly      = (acc + 64'sd32768) >>> 16;
      wet_term = (longint'(wet) * dly + 64'sd16384) >>> 15;

      tap_line[head_index] = x;
      head_index = (head_index + 1) % len;
      lfo_acc    = lfo_acc + cfg_step;

      y = longint'(x) + wet_term;
      if (y > 32767) y = 32767;
      else if (y < -32768) y = -32768;
      return y[15:0];
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         default: return sample_type'($urandom());
      endcase
   endfunction

   task automatic set_idling(input int send_pct, input int recv_pct);
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
   endtask

   // Offer one sample beat, idling first at the sender's rate; record its prediction
   task automatic send_sample(input sample_type x);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= x;
      do @(posedge clock); while (!req_bus.ready);
      expected_samples.push_back(mix_chorus_sample(x));
      samples_sent++;
   endtask

   // Drop the sample channel and hold until every predicted sample has been checked
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_samples.size() != 0);
   endtask

   // Leave csr valid high; the caller drops it after the last beat of a batch
   task automatic csr_write(input csr_index_type idx, input csr_data_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_DELAY_LENGTH: cfg_length = data[11:0];
         CSR_PHASE_STEP:   cfg_step   = data;
         CSR_WET_LEVEL:    cfg_wet    = data[15:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_registers(input csr_data_type len_word, input csr_data_type step_word,
                                input csr_data_type wet_word);
      csr_write(CSR_DELAY_LENGTH, len_word);
      csr_write(CSR_PHASE_STEP, step_word);
      csr_write(CSR_WET_LEVEL, wet_word);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // Reset settings, empty delay line: output must track the input
   task automatic test_reset_state();
      send_sample(16'sh0000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0001);
      send_sample(16'shFFFF);
      send_sample(16'sh5555);
      wait_for_results();
   endtask

   // Head sits past a shortened length and must restart at zero
   task automatic test_pointer_restart();
      set_registers(32'd4, PHASE_STEP_RESET, 32'(WET_LEVEL_RESET));
      send_sample(16'shAAAA);
      send_sample(16'sh1234);
      send_sample(16'shEDCB);
      wait_for_results();
   endtask

   // Quarter-turn LFO steps land on every quadrant while the phase is still in the first bin:
   // peak delay reads the slot about to be overwritten, and the trough's zero delay wraps to that same slot
   task automatic test_lfo_quadrants();
      set_registers(32'd3, 32'h4000_0000, 32'd32768);
      send_sample(16'sh4000);
      send_sample(16'shC000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8001);
      send_sample(16'sh0F0F);
      wait_for_results();
   endtask

   // Zero length acts as one, overlong lengths clamp; a full-scale step wraps the phase
   task automatic test_length_limits();
      set_registers(32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_8000);
      send_sample(16'sh6000);
      send_sample(16'shA000);
      wait_for_results();
      set_registers(32'hFFFF_F800, 32'hFFFF_FFFF, 32'd32768);
      send_sample(16'sh3C3C);
      send_sample(16'shC3C3);
      wait_for_results();
      set_registers(32'h0000_0FFF, 32'h8000_0001, 32'd32768);
      send_sample(16'sh7001);
      send_sample(16'sh8FFE);
      wait_for_results();
   endtask

   // Single-slot line echoes the previous sample; excess wet clamps, both rails saturate
   task automatic test_wet_saturation();
      set_registers(32'd1, 32'd0, 32'h0000_FFFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      wait_for_results();
      set_registers(32'd1, 32'd0, 32'd0);
      send_sample(16'sh7FFF);
      wait_for_results();
   endtask

   task automatic test_unknown_register();
      csr_write(CSR_SPARE, $urandom());
      csr_bus.valid <= 1'b0;
      send_sample(16'sh2468);
      wait_for_results();
   endtask

   // Hold the output off for a long stretch while beats keep coming; the block must stall
   task automatic test_output_backpressure();
      set_registers(32'd64, 32'd1000000, 32'd20000);
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (30) send_sample(random_sample());
      wait_for_results();
   endtask

   // Sender pauses until the block has delivered everything, then resumes
   task automatic test_sender_pause();
      repeat (10) send_sample(random_sample());
      wait_for_results();
      repeat (10) send_sample(random_sample());
      wait_for_results();
   endtask

   task automatic pick_random_settings();
      logic [11:0]  len;
      csr_data_type step;
      logic [15:0]  wet;
      case ($urandom_range(9))
         0:       len = 12'd0;
         1:       len = 12'd1;
         2:       len = 12'd2048;
         3:       len = 12'hFFF;
         4:       len = 12'd2;
         default: len = 12'($urandom_range(1, MAX_DELAY));
      endcase
      case ($urandom_range(7))
         0:       step = 32'd0;
         1:       step = 32'hFFFF_FFFF;
         2:       step = $urandom();
         default: step = $urandom_range(0, 2000000);
      endcase
      case ($urandom_range(7))
         0:       wet = 16'd0;
         1:       wet = WET_FULL;
         2:       wet = 16'hFFFF;
         default: wet = 16'($urandom_range(0, 32768));
      endcase
      set_registers({20'($urandom_range(0, 20'hFFFFF)), len}, step,
                    {16'($urandom_range(0, 16'hFFFF)), wet});
   endtask

   // Segments of random beats, each under fresh settings written while the block is idle
   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
      int target;
      int n;
      target = samples_sent + count;
      set_idling(send_pct, recv_pct);
      while (samples_sent < target) begin
         pick_random_settings();
         n = $urandom_range(20, 80);
         if (n > target - samples_sent) n = target - samples_sent;
         repeat (n) send_sample(random_sample());
         wait_for_results();
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("** chorus_modulated_delay_top: FAILED **");
         $finish;
      end
   end

   // Output ready: counted hold-off first, otherwise idle at the receiver's rate
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Compare each output beat with the oldest prediction
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: sample_out expected none, actual %0d", $time, rsp_bus.sample_out);
            mismatch_count++;
         end else begin
            want = expected_samples.pop_front();
            results_checked++;
            if (rsp_bus.sample_out !== want) begin
               $display("%0t: sample_out expected %0d, actual %0d",
                        $time, want, rsp_bus.sample_out);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int              k;
      longint unsigned t, u, a, r;

      // Quarter-wave sine in Q15, Horner evaluation in Q30
      for (k = 0; k <= SINE_ENTRIES; k++) begin
         t = (longint'(k) * Q30_ONE) / SINE_ENTRIES;
         u = (t * t) >> 30;
         a = SIN_C7 - ((u * SIN_C9) >> 30);
         a = SIN_C5 - ((u * a) >> 30);
         a = SIN_C3 - ((u * a) >> 30);
         a = SIN_C1 - ((u * a) >> 30);
         r = (t * a) >> 30;
         r = (r + 64'd16384) >> 15;
         quarter_wave[k] = (r > 64'd32768) ? 32768 : int'(r);
      end
      for (k = 0; k < MAX_DELAY; k++) tap_line[k] = '0;
      head_index = 0;
      lfo_acc    = '0;
      cfg_length = DELAY_LENGTH_RESET;
      cfg_step   = PHASE_STEP_RESET;
      cfg_wet    = WET_LEVEL_RESET;

      // Drive every input to a known value before the first edge
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.sample_in = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_DELAY_LENGTH;
      csr_bus.wdata     = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_idling(8, 71);
      test_reset_state();
      test_pointer_restart();
      test_lfo_quadrants();
      test_length_limits();
      test_wet_saturation();
      test_unknown_register();
      test_output_backpressure();
      test_sender_pause();
      test_random_traffic(8, 71, 330);
      test_random_traffic(71, 8, 330);
      test_random_traffic(0, 0, 330);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d sample beats and %0d checked outputs under %0d settings,",
               samples_sent, results_checked, settings_used);
      $display("with %0d register writes, LFO quadrant and length edges, saturation and stalls.",
               csr_writes);
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("** chorus_modulated_delay_top: PASSED **");
      end else begin
         $display("** chorus_modulated_delay_top: FAILED **");
      end
      $finish;
   end

endmodule
